// ===== rtl/ctp_pkg.sv =====
package ctp_pkg;

    // Width of one multiplier digit; each multiplier stage handles one digit of its i_b operand.
    localparam int DIGIT_W = 16;

    // Number of digit stages that a multiplier needs for an i_b operand of the given width.
    function automatic int mul_lat(input int bw);
        return (bw + DIGIT_W - 1) / DIGIT_W;
    endfunction

endpackage

// ===== rtl/ctp_dly.sv =====
module ctp_dly #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic [WIDTH-1:0] i_d,
    output logic [WIDTH-1:0] o_q
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    always_ff @(posedge i_clk) begin
        r_tap[0] <= i_d;
        for (int k = 1; k < DEPTH; k++) begin
            r_tap[k] <= r_tap[k-1];
        end
    end

    assign o_q = r_tap[DEPTH-1];

endmodule

// ===== rtl/ctp_mul.sv =====
module ctp_mul #(
    parameter int AW = 32,
    parameter int BW = 32
) (
    input  logic             i_clk,
    input  logic [AW-1:0]    i_a,
    input  logic [BW-1:0]    i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int DW  = ctp_pkg::DIGIT_W;
    localparam int ND  = ctp_pkg::mul_lat(BW);
    localparam int BPW = ND * DW;
    localparam int PW  = AW + BW;
    localparam int PPW = AW + DW;

    logic [AW-1:0]  r_a   [ND];
    logic [BPW-1:0] r_b   [ND];
    logic [PW-1:0]  r_acc [ND];

    // Each stage multiplies the i_a operand by one digit of i_b and adds it in at its weight.
    for (genvar k = 0; k < ND; k++) begin : g_stage
        logic [AW-1:0]  a_in;
        logic [BPW-1:0] b_in;
        logic [PW-1:0]  acc_in;
        logic [PPW-1:0] pp;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = BPW'(i_b);
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        assign pp = PPW'(a_in) * PPW'(b_in[k*DW +: DW]);

        always_ff @(posedge i_clk) begin
            r_acc[k] <= acc_in + (PW'(pp) << (k * DW));
        end

        if (k < ND - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_a[k] <= a_in;
                r_b[k] <= b_in;
            end
        end
    end

    assign o_p = r_acc[ND-1];

endmodule

// ===== rtl/ctp_sqrt.sv =====
module ctp_sqrt #(
    parameter int RW = 33
) (
    input  logic              i_clk,
    input  logic [2*RW-1:0]   i_rad,
    output logic [RW-1:0]     o_root
);

    logic [RW+1:0]   r_rem  [RW];
    logic [RW-1:0]   r_root [RW];
    logic [2*RW-1:0] r_rad  [RW];

    // One root bit per stage, taking two radicand bits each time.
    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+1:0]   rem_in;
        logic [RW-1:0]   root_in;
        logic [2*RW-1:0] rad_in;
        logic [RW+3:0]   t_rem;
        logic [RW+3:0]   trial;
        logic            ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = i_rad;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign rad_in  = r_rad[k-1];
        end

        assign t_rem = {rem_in, rad_in[2*RW-1 -: 2]};
        assign trial = (RW+4)'({root_in, 2'b01});
        assign ge    = (t_rem >= trial);

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? (RW+2)'(t_rem - trial) : (RW+2)'(t_rem);
            r_root[k] <= {root_in[RW-2:0], ge};
            r_rad[k]  <= rad_in << 2;
        end
    end

    assign o_root = r_root[RW-1];

endmodule

// ===== rtl/ctp_div.sv =====
module ctp_div #(
    parameter int NW  = 98,
    parameter int DNW = 66,
    parameter int QW  = 32
) (
    input  logic           i_clk,
    input  logic [NW-1:0]  i_num,
    input  logic [DNW-1:0] i_den,
    output logic [QW-1:0]  o_q
);

    logic [DNW-1:0] r_rem [QW];
    logic [QW-1:0]  r_lo  [QW];
    logic [DNW-1:0] r_den [QW];
    logic [QW-1:0]  r_qt  [QW];
    logic [QW-1:0]  r_q;

    // The quotient is known to fit QW bits, so the bits above QW seed the remainder.
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DNW-1:0] rem_in;
        logic [QW-1:0]  lo_in;
        logic [DNW-1:0] den_in;
        logic [QW-1:0]  q_in;
        logic [DNW:0]   t_rem;
        logic           ge;

        if (k == 0) begin : g_first
            assign rem_in = DNW'(i_num >> QW);
            assign lo_in  = i_num[QW-1:0];
            assign den_in = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign lo_in  = r_lo[k-1];
            assign den_in = r_den[k-1];
            assign q_in   = r_qt[k-1];
        end

        assign t_rem = {rem_in, lo_in[QW-1]};
        assign ge    = (t_rem >= {1'b0, den_in});

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? DNW'(t_rem - {1'b0, den_in}) : DNW'(t_rem);
            r_lo[k]  <= lo_in << 1;
            r_den[k] <= den_in;
            r_qt[k]  <= {q_in[QW-2:0], ge};
        end
    end

    // Round half up: bump the quotient when twice the remainder reaches the divisor.
    always_ff @(posedge i_clk) begin
        r_q <= r_qt[QW-1] + QW'({r_rem[QW-1], 1'b0} >= {1'b0, r_den[QW-1]});
    end

    assign o_q = r_q;

endmodule

// ===== rtl/ctp_front.sv =====
module ctp_front #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  logic signed [W-1:0] i_point_x,
    input  logic signed [W-1:0] i_point_y,
    input  logic signed [W-1:0] i_center_x,
    input  logic signed [W-1:0] i_center_y,
    input  logic [W-2:0]        i_radius,
    output logic                o_vld,
    output logic                o_nx,
    output logic                o_ny,
    output logic [W:0]          o_adx,
    output logic [W:0]          o_ady,
    output logic [W-2:0]        o_radius,
    output logic [W-1:0]        o_center_x,
    output logic [W-1:0]        o_center_y
);

    localparam int QDEPTH = 2;
    localparam int PTRW   = $clog2(QDEPTH);
    localparam int CNTW   = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic         nx;
        logic         ny;
        logic [W:0]   adx;
        logic [W:0]   ady;
        logic [W-2:0] radius;
        logic [W-1:0] cx;
        logic [W-1:0] cy;
    } t_entry;

    logic signed [W:0] dx;
    logic signed [W:0] dy;
    t_entry            entry;
    logic              push;
    logic              pop;
    logic [CNTW-1:0]   n_cnt;

    t_entry          r_mem [QDEPTH];
    t_entry          r_head;
    logic            r_ovld;
    logic [PTRW-1:0] r_wp;
    logic [PTRW-1:0] r_rp;
    logic [CNTW-1:0] r_cnt;

    // Classify the item: offset from the center split into sign and magnitude.
    assign dx = $signed({i_point_x[W-1], i_point_x}) - $signed({i_center_x[W-1], i_center_x});
    assign dy = $signed({i_point_y[W-1], i_point_y}) - $signed({i_center_y[W-1], i_center_y});

    always_comb begin
        entry.nx     = dx[W];
        entry.ny     = dy[W];
        entry.adx    = dx[W] ? -dx : dx;
        entry.ady    = dy[W] ? -dy : dy;
        entry.radius = i_radius;
        entry.cx     = i_center_x;
        entry.cy     = i_center_y;
    end

    assign o_busy = (r_cnt == CNTW'(QDEPTH)) || !i_rst_n;
    assign push   = i_start && !o_busy;
    assign pop    = (r_cnt != '0);

    always_comb begin
        n_cnt = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_cnt  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_ovld <= pop;
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= entry;
        end
        if (pop) begin
            r_head <= r_mem[r_rp];
        end
    end

    assign o_vld      = r_ovld;
    assign o_nx       = r_head.nx;
    assign o_ny       = r_head.ny;
    assign o_adx      = r_head.adx;
    assign o_ady      = r_head.ady;
    assign o_radius   = r_head.radius;
    assign o_center_x = r_head.cx;
    assign o_center_y = r_head.cy;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNTW'(QDEPTH))
        else $error("queue count above depth");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_vld |-> $past(r_cnt) != '0)
        else $error("item handed to back end from an empty queue");

endmodule

// ===== rtl/ctp_back.sv =====
module ctp_back #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    input  logic                i_nx,
    input  logic                i_ny,
    input  logic [W:0]          i_adx,
    input  logic [W:0]          i_ady,
    input  logic [W-2:0]        i_radius,
    input  logic [W-1:0]        i_center_x,
    input  logic [W-1:0]        i_center_y,
    output logic                o_valid,
    output logic                o_outside,
    output logic signed [W-1:0] o_first_x,
    output logic signed [W-1:0] o_first_y,
    output logic signed [W-1:0] o_second_x,
    output logic signed [W-1:0] o_second_y
);

    localparam int AXW = W + 1;
    localparam int RW  = W - 1;
    localparam int R2W = 2 * W - 2;
    localparam int SW  = 2 * W + 2;
    localparam int HW  = W + 1;
    localparam int RHW = 2 * W;
    localparam int A1W = R2W + AXW;
    localparam int B1W = RHW + AXW;
    localparam int NSW = 3 * W + 3;
    localparam int MW  = 3 * W + 2;
    localparam int QW  = W;

    localparam int LM    = ctp_pkg::mul_lat(AXW);
    localparam int T_S   = LM + 1;
    localparam int T_D   = LM + 2;
    localparam int T_H   = T_D + HW;
    localparam int T_RH  = T_H + LM;
    localparam int T_N   = T_RH + LM;
    localparam int T_MAG = T_N + 3;
    localparam int T_Q   = T_MAG + QW + 1;
    localparam int T_OUT = T_Q + 1;

    logic [SW-1:0]    sqx;
    logic [SW-1:0]    sqy;
    logic [RW+AXW-1:0] rr;
    logic [HW-1:0]    h;
    logic [RW-1:0]    r_at_h;
    logic [RHW-1:0]   rh;
    logic [R2W-1:0]   r2_at_n;
    logic [AXW-1:0]   adx_n;
    logic [AXW-1:0]   ady_n;
    logic [A1W-1:0]   a1;
    logic [A1W-1:0]   a2;
    logic [B1W-1:0]   b1;
    logic [B1W-1:0]   b2;
    logic [1:0]       sgn_n;
    logic [SW-1:0]    s_m;
    logic [3:0]       neg_q;
    logic             gt_q;
    logic [W-1:0]     cx_q;
    logic [W-1:0]     cy_q;
    logic [QW-1:0]    quo [4];
    logic signed [NSW-1:0] sums [4];

    logic [SW-1:0]         r_s;
    logic [R2W-1:0]        r_r2;
    logic                  r_gt;
    logic [SW-1:0]         r_diff;
    logic signed [NSW-1:0] r_ta1;
    logic signed [NSW-1:0] r_tb1;
    logic signed [NSW-1:0] r_ta2;
    logic signed [NSW-1:0] r_tb2;
    logic signed [NSW-1:0] r_fx;
    logic signed [NSW-1:0] r_fy;
    logic signed [NSW-1:0] r_sx;
    logic signed [NSW-1:0] r_sy;
    logic [3:0]            r_neg;
    logic [MW-1:0]         r_mag [4];
    logic [T_OUT-1:0]      r_vld;
    logic                  r_outside;
    logic [W-1:0]          r_first_x;
    logic [W-1:0]          r_first_y;
    logic [W-1:0]          r_second_x;
    logic [W-1:0]          r_second_y;

    // Center plus or minus the rounded offset, clamped to the coordinate range.
    function automatic logic [W-1:0] place(input logic [W-1:0] c, input logic ng,
                                           input logic [QW-1:0] q);
        logic signed [W+1:0] ce;
        logic signed [W+1:0] qe;
        logic signed [W+1:0] v;
        logic signed [W+1:0] hi;
        logic signed [W+1:0] lo;
        ce = $signed({{2{c[W-1]}}, c});
        qe = $signed({2'b00, q});
        v  = ng ? (ce - qe) : (ce + qe);
        hi = $signed({3'b000, {(W-1){1'b1}}});
        lo = $signed({3'b111, {(W-1){1'b0}}});
        if (v > hi) begin
            return {1'b0, {(W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(W-1){1'b0}}};
        end
        return v[W-1:0];
    endfunction

    // Squared distance and squared radius.
    ctp_mul #(.AW(AXW), .BW(AXW)) u_sqx (.i_clk(i_clk), .i_a(i_adx), .i_b(i_adx), .o_p(sqx));
    ctp_mul #(.AW(AXW), .BW(AXW)) u_sqy (.i_clk(i_clk), .i_a(i_ady), .i_b(i_ady), .o_p(sqy));
    ctp_mul #(.AW(RW), .BW(AXW)) u_rr (
        .i_clk(i_clk), .i_a(i_radius), .i_b(AXW'(i_radius)), .o_p(rr)
    );

    always_ff @(posedge i_clk) begin
        r_s    <= sqx + sqy;
        r_r2   <= rr[R2W-1:0];
        r_gt   <= (r_s > SW'(r_r2));
        r_diff <= r_s - SW'(r_r2);
    end

    ctp_sqrt #(.RW(HW)) u_sqrt (.i_clk(i_clk), .i_rad(r_diff), .o_root(h));

    ctp_dly #(.WIDTH(RW), .DEPTH(T_H)) u_dly_r (.i_clk(i_clk), .i_d(i_radius), .o_q(r_at_h));

    ctp_mul #(.AW(RW), .BW(HW)) u_rh (.i_clk(i_clk), .i_a(r_at_h), .i_b(h), .o_p(rh));

    ctp_dly #(.WIDTH(R2W), .DEPTH(T_RH - T_S)) u_dly_r2 (
        .i_clk(i_clk), .i_d(r_r2), .o_q(r2_at_n)
    );
    ctp_dly #(.WIDTH(2 * AXW), .DEPTH(T_RH)) u_dly_ad (
        .i_clk(i_clk), .i_d({i_adx, i_ady}), .o_q({adx_n, ady_n})
    );

    // Numerator terms r^2*|d| and r*h*|d|.
    ctp_mul #(.AW(R2W), .BW(AXW)) u_a1 (.i_clk(i_clk), .i_a(r2_at_n), .i_b(adx_n), .o_p(a1));
    ctp_mul #(.AW(R2W), .BW(AXW)) u_a2 (.i_clk(i_clk), .i_a(r2_at_n), .i_b(ady_n), .o_p(a2));
    ctp_mul #(.AW(RHW), .BW(AXW)) u_b1 (.i_clk(i_clk), .i_a(rh), .i_b(ady_n), .o_p(b1));
    ctp_mul #(.AW(RHW), .BW(AXW)) u_b2 (.i_clk(i_clk), .i_a(rh), .i_b(adx_n), .o_p(b2));

    ctp_dly #(.WIDTH(2), .DEPTH(T_N)) u_dly_sgn (
        .i_clk(i_clk), .i_d({i_nx, i_ny}), .o_q(sgn_n)
    );

    // Signed terms, then the four signed numerators, then sign and magnitude.
    always_ff @(posedge i_clk) begin
        r_ta1 <= sgn_n[1] ? -NSW'(a1) : NSW'(a1);
        r_tb1 <= sgn_n[0] ? -NSW'(b1) : NSW'(b1);
        r_ta2 <= sgn_n[0] ? -NSW'(a2) : NSW'(a2);
        r_tb2 <= sgn_n[1] ? -NSW'(b2) : NSW'(b2);
        r_fx  <= r_ta1 - r_tb1;
        r_sx  <= r_ta1 + r_tb1;
        r_fy  <= r_ta2 + r_tb2;
        r_sy  <= r_ta2 - r_tb2;
    end

    assign sums[0] = r_fx;
    assign sums[1] = r_fy;
    assign sums[2] = r_sx;
    assign sums[3] = r_sy;

    ctp_dly #(.WIDTH(SW), .DEPTH(T_MAG - T_S)) u_dly_s (.i_clk(i_clk), .i_d(r_s), .o_q(s_m));

    for (genvar k = 0; k < 4; k++) begin : g_lane
        always_ff @(posedge i_clk) begin
            r_neg[k] <= sums[k][NSW-1];
            r_mag[k] <= sums[k][NSW-1] ? MW'(-sums[k]) : MW'(sums[k]);
        end

        ctp_div #(.NW(MW), .DNW(SW), .QW(QW)) u_div (
            .i_clk(i_clk), .i_num(r_mag[k]), .i_den(s_m), .o_q(quo[k])
        );
    end

    ctp_dly #(.WIDTH(4), .DEPTH(QW + 1)) u_dly_neg (.i_clk(i_clk), .i_d(r_neg), .o_q(neg_q));
    ctp_dly #(.WIDTH(1), .DEPTH(T_Q - T_D)) u_dly_gt (.i_clk(i_clk), .i_d(r_gt), .o_q(gt_q));
    ctp_dly #(.WIDTH(2 * W), .DEPTH(T_Q)) u_dly_c (
        .i_clk(i_clk), .i_d({i_center_x, i_center_y}), .o_q({cx_q, cy_q})
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld     <= '0;
            r_outside <= 1'b0;
        end else begin
            r_vld     <= {r_vld[T_OUT-2:0], i_vld};
            r_outside <= r_vld[T_Q-1] && gt_q;
        end
    end

    always_ff @(posedge i_clk) begin
        r_first_x  <= gt_q ? place(cx_q, neg_q[0], quo[0]) : '0;
        r_first_y  <= gt_q ? place(cy_q, neg_q[1], quo[1]) : '0;
        r_second_x <= gt_q ? place(cx_q, neg_q[2], quo[2]) : '0;
        r_second_y <= gt_q ? place(cy_q, neg_q[3], quo[3]) : '0;
    end

    assign o_valid    = r_vld[T_OUT-1];
    assign o_outside  = r_outside;
    assign o_first_x  = r_first_x;
    assign o_first_y  = r_first_y;
    assign o_second_x = r_second_x;
    assign o_second_y = r_second_y;

    a_vld_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_vld, T_OUT))
        else $error("result without an item entering the back end");

    a_outside_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_outside |-> o_valid)
        else $error("outside flag raised outside a result cycle");

    a_inside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_outside) |-> (o_first_x == '0 && o_first_y == '0 &&
                                     o_second_x == '0 && o_second_y == '0))
        else $error("nonzero points for a point not outside the circle");

endmodule

// ===== rtl/circle_tangent_points.sv =====
// Tangent points from an external point to a circle.
//
// An item (point, center, radius, all fixed point) is offered on the i_ fields with start;
// it is taken at a rising edge where start is high and busy is low. busy is high only while
// reset is held or the input queue is full; since the back end never stalls, it stays low
// otherwise and one item can be taken every cycle.
// Each item gives exactly one result, shown for one cycle with o_valid high. o_outside is
// 1 when the point lies strictly outside the circle, and then o_first_* and o_second_* hold
// the two tangent points (first at the angle plus the tangent half angle, second minus),
// rounded to nearest and clamped to the coordinate range; otherwise all points read zero.
// On its way to the ports the result passes the queue, the 16-bit digit multiplier stages,
// the bit-per-stage square root (COORD_WIDTH+1 stages) and the bit-per-stage rounding
// dividers (COORD_WIDTH+1 stages). Throughput is one item per cycle.
// The result side has no handshake: the receiver must take each result in its strobe cycle.
// Reset is synchronous and active low; it empties the queue and drops every item in flight.
module circle_tangent_points #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_point_x,
    input  logic signed [COORD_WIDTH-1:0] i_point_y,
    input  logic signed [COORD_WIDTH-1:0] i_center_x,
    input  logic signed [COORD_WIDTH-1:0] i_center_y,
    input  logic [COORD_WIDTH-2:0]        i_radius,
    output logic                          o_valid,
    output logic                          o_outside,
    output logic signed [COORD_WIDTH-1:0] o_first_x,
    output logic signed [COORD_WIDTH-1:0] o_first_y,
    output logic signed [COORD_WIDTH-1:0] o_second_x,
    output logic signed [COORD_WIDTH-1:0] o_second_y
);

    localparam int W = COORD_WIDTH;

    // Front end to back end: one queued item per cycle.
    logic         q_vld;
    logic         q_nx;
    logic         q_ny;
    logic [W:0]   q_adx;
    logic [W:0]   q_ady;
    logic [W-2:0] q_radius;
    logic [W-1:0] q_cx;
    logic [W-1:0] q_cy;

    // The front end takes the item, forms the offset from the center as sign and
    // magnitude, and parks it in a two-entry queue.
    ctp_front #(.W(W)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_point_x  (i_point_x),
        .i_point_y  (i_point_y),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius   (i_radius),
        .o_vld      (q_vld),
        .o_nx       (q_nx),
        .o_ny       (q_ny),
        .o_adx      (q_adx),
        .o_ady      (q_ady),
        .o_radius   (q_radius),
        .o_center_x (q_cx),
        .o_center_y (q_cy)
    );

    // The back end is a fixed-latency pipeline: squares, the outside test, square root,
    // numerator products, four rounding dividers and the final clamp.
    ctp_back #(.W(W)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .i_nx       (q_nx),
        .i_ny       (q_ny),
        .i_adx      (q_adx),
        .i_ady      (q_ady),
        .i_radius   (q_radius),
        .i_center_x (q_cx),
        .i_center_y (q_cy),
        .o_valid    (o_valid),
        .o_outside  (o_outside),
        .o_first_x  (o_first_x),
        .o_first_y  (o_first_y),
        .o_second_x (o_second_x),
        .o_second_y (o_second_y)
    );

endmodule
